FILE: design/rpsr_pkg.sv
// ----------------------------------------------------------------------------
// rpsr_pkg
// Shared types and constants of the record packet size regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpsr_pkg;

   // frames delivered by one receive block
   localparam int BLOCK_FRAMES = 48;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type REG_NOMINAL_FRAMES = csr_index_type'(0);
   localparam csr_index_type REG_TARGET_FILL    = csr_index_type'(1);
   localparam csr_index_type REG_BAND           = csr_index_type'(2);
   localparam csr_index_type REG_MAX_FILL       = csr_index_type'(3);

   localparam logic [9:0]  NOMINAL_FRAMES_RESET = 10'd48;
   localparam logic [15:0] TARGET_FILL_RESET    = 16'd96;
   localparam logic [7:0]  BAND_RESET           = 8'd8;
   localparam logic [15:0] MAX_FILL_RESET       = 16'd288;

   typedef struct packed {
      logic [9:0]  nominal_frames;
      logic [15:0] target_fill;
      logic [7:0]  band;
      logic [15:0] max_fill;
   } cfg_type;

   // tick as held in the input register, ring head already scaled to frames
   typedef struct packed {
      logic [31:0] ring_head;
      logic        record_active;
      logic        port_restarted;
      logic        stream_reopened;
      logic        buffer_free;
      logic        send_accepted;
   } stage_type;

   typedef struct packed {
      logic        packet_valid;
      logic [10:0] packet_frames;
      logic [31:0] read_start;
      logic [10:0] consumed_frames;
      logic        overflow_seen;
      logic        raised;
      logic        lowered;
      logic        underrun_seen;
      logic        no_buffer;
      logic        send_refused;
   } result_type;

endpackage

`default_nettype wire

FILE: design/rpsr_req_if.sv
// ----------------------------------------------------------------------------
// rpsr_req_if
// Tick channel: one transfer per start-of-frame tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpsr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] rx_blocks_done;
   logic        record_active;
   logic        port_restarted;
   logic        stream_reopened;
   logic        buffer_free;
   logic        send_accepted;

   modport source (
      output valid, rx_blocks_done, record_active, port_restarted,
             stream_reopened, buffer_free, send_accepted,
      input  ready
   );
   modport sink (
      input  valid, rx_blocks_done, record_active, port_restarted,
             stream_reopened, buffer_free, send_accepted,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/rpsr_rsp_if.sv
// ----------------------------------------------------------------------------
// rpsr_rsp_if
// Packet decision channel: one transfer per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpsr_rsp_if;
   logic        valid;
   logic        ready;
   logic        packet_valid;
   logic [10:0] packet_frames;
   logic [31:0] read_start;
   logic [10:0] consumed_frames;
   logic        overflow_seen;
   logic        raised;
   logic        lowered;
   logic        underrun_seen;
   logic        no_buffer;
   logic        send_refused;

   modport source (
      output valid, packet_valid, packet_frames, read_start, consumed_frames,
             overflow_seen, raised, lowered, underrun_seen, no_buffer,
             send_refused,
      input  ready
   );
   modport sink (
      input  valid, packet_valid, packet_frames, read_start, consumed_frames,
             overflow_seen, raised, lowered, underrun_seen, no_buffer,
             send_refused,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/rpsr_csr_if.sv
// ----------------------------------------------------------------------------
// rpsr_csr_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpsr_csr_if;
   import rpsr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

FILE: design/rpsr_csr_regs.sv
// ----------------------------------------------------------------------------
// rpsr_csr_regs
// Configuration registers, written one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsr_csr_regs (
   input  logic             clock,
   input  logic             reset,
   rpsr_csr_if.sink         csr_ch,
   output rpsr_pkg::cfg_type cfg
);
   import rpsr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_NOMINAL_FRAMES: cfg_in.nominal_frames = csr_ch.wdata[9:0];
            REG_TARGET_FILL:    cfg_in.target_fill    = csr_ch.wdata[15:0];
            REG_BAND:           cfg_in.band           = csr_ch.wdata[7:0];
            REG_MAX_FILL:       cfg_in.max_fill       = csr_ch.wdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_frames <= NOMINAL_FRAMES_RESET;
         cfg_ff.target_fill    <= TARGET_FILL_RESET;
         cfg_ff.band           <= BAND_RESET;
         cfg_ff.max_fill       <= MAX_FILL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/rpsr_in_stage.sv
// ----------------------------------------------------------------------------
// rpsr_in_stage
// Input register; scales the receive block count to a ring head in frames.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsr_in_stage (
   input  logic               clock,
   input  logic               reset,
   rpsr_req_if.sink           req_ch,
   output logic               stage_valid,
   output rpsr_pkg::stage_type stage_data,
   input  logic               stage_ready
);
   import rpsr_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   stage_type data_ff;
   stage_type data_in;
   logic      take;

   assign req_ch.ready = !valid_ff || stage_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign stage_valid  = valid_ff;
   assign stage_data   = data_ff;

   always_comb begin
      data_in                 = data_ff;
      valid_in                = valid_ff;
      if (take) begin
         data_in.ring_head       = 32'(req_ch.rx_blocks_done * 32'(BLOCK_FRAMES));
         data_in.record_active   = req_ch.record_active;
         data_in.port_restarted  = req_ch.port_restarted;
         data_in.stream_reopened = req_ch.stream_reopened;
         data_in.buffer_free     = req_ch.buffer_free;
         data_in.send_accepted   = req_ch.send_accepted;
         valid_in                = 1'b1;
      end else if (stage_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

FILE: design/rpsr_core.sv
// ----------------------------------------------------------------------------
// rpsr_core
// Fill tracking, averaging and packet sizing; holds the regulator state and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpsr_core (
   input  logic                clock,
   input  logic                reset,
   input  rpsr_pkg::cfg_type   cfg,
   input  logic                stage_valid,
   input  rpsr_pkg::stage_type stage_data,
   output logic                stage_ready,
   output logic                rsp_valid,
   output rpsr_pkg::result_type rsp_data,
   input  logic                rsp_ready
);
   import rpsr_pkg::*;

   logic [31:0]        read_position_ff, read_position_in;
   logic signed [31:0] fill_average_ff, fill_average_in;
   logic               started_ff, started_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic               advance;
   logic [31:0]        pos_a, pos_b;
   logic signed [31:0] avg_a, avg_b, avg_c, diff, avg_frames;
   logic               started_a;
   logic signed [31:0] fill0, fill1;
   logic signed [31:0] target_s, max_s, band_s, hi_lim, lo_lim;
   logic               overflow, go;
   logic               raise, lower;
   logic [10:0]        frames;
   logic [10:0]        consumed;
   logic               underrun;
   result_type         res;

   assign stage_ready = !rsp_valid_ff || rsp_ready;
   assign advance     = stage_valid && stage_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   assign target_s = $signed({16'd0, cfg.target_fill});
   assign max_s    = $signed({16'd0, cfg.max_fill});
   assign band_s   = $signed({24'd0, cfg.band});
   assign hi_lim   = target_s + band_s;
   assign lo_lim   = target_s - band_s;

   always_comb begin
      // restart and reopen act before anything else
      pos_a     = stage_data.port_restarted ? 32'd0 : read_position_ff;
      avg_a     = stage_data.port_restarted ? 32'sd0 : fill_average_ff;
      started_a = started_ff && !stage_data.port_restarted && !stage_data.stream_reopened;

      fill0 = $signed(stage_data.ring_head - pos_a);
      go    = stage_data.record_active && (started_a || !(fill0 < target_s));

      overflow = fill0 > max_s;
      if (overflow) begin
         pos_b = stage_data.ring_head - {16'd0, cfg.target_fill};
         avg_b = $signed({12'd0, cfg.target_fill, 4'd0});
         fill1 = target_s;
      end else begin
         pos_b = pos_a;
         avg_b = started_a ? avg_a : (fill0 <<< 4);
         fill1 = fill0;
      end

      diff       = (fill1 <<< 4) - avg_b;
      avg_c      = avg_b + (diff >>> 3);
      avg_frames = avg_c >>> 4;

      raise = avg_frames > hi_lim;
      lower = !raise && (avg_frames < lo_lim);
      if (raise) begin
         frames = {1'b0, cfg.nominal_frames} + 11'd1;
      end else if (lower) begin
         frames = (cfg.nominal_frames == 10'd0) ? 11'd0 : {1'b0, cfg.nominal_frames} - 11'd1;
      end else begin
         frames = {1'b0, cfg.nominal_frames};
      end

      // short ring: take what is there, pad the rest
      underrun = fill1 < $signed({21'd0, frames});
      if (!underrun) begin
         consumed = frames;
      end else if (fill1 > 32'sd0) begin
         consumed = fill1[10:0];
      end else begin
         consumed = 11'd0;
      end

      res = '0;
      if (go) begin
         res.packet_frames = frames;
         res.read_start    = pos_b;
         res.overflow_seen = overflow;
         res.raised        = raise;
         res.lowered       = lower;
         if (!stage_data.buffer_free) begin
            res.no_buffer = 1'b1;
         end else begin
            res.underrun_seen   = underrun;
            res.consumed_frames = consumed;
            res.send_refused    = !stage_data.send_accepted;
            res.packet_valid    = stage_data.send_accepted;
         end
      end

      read_position_in = read_position_ff;
      fill_average_in  = fill_average_ff;
      started_in       = started_ff;
      if (advance) begin
         if (go) begin
            started_in       = 1'b1;
            fill_average_in  = avg_c;
            read_position_in = res.packet_valid ? pos_b + {21'd0, consumed} : pos_b;
         end else begin
            started_in       = 1'b0;
            fill_average_in  = avg_a;
            read_position_in = pos_a;
         end
      end

      rsp_data_in  = advance ? res : rsp_data_ff;
      rsp_valid_in = stage_ready ? stage_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_position_ff <= 32'd0;
         fill_average_ff  <= 32'sd0;
         started_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         read_position_ff <= read_position_in;
         fill_average_ff  <= fill_average_in;
         started_ff       <= started_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: design/record_packet_size_regulator.sv
// ----------------------------------------------------------------------------
// record_packet_size_regulator
// Sizes each record packet from the receive ring fill, one decision per tick.
// ----------------------------------------------------------------------------
// Each tick transfer yields exactly one decision transfer. A tick is taken
// into an input register, where the block count is scaled to a ring head;
// from that register the fill, the averaged fill and the packet size are
// worked out and the read position, average and started flag are updated
// together with the result register. While rsp_ch.ready stays high a new
// tick is taken every cycle, set by that one update stage. The tick
// channel keeps accepting while a decision waits for rsp_ch.ready, as long
// as the input register is free. Register writes are taken in any cycle
// and are meant to happen only while no tick is in flight.
`default_nettype none

module record_packet_size_regulator (
   input logic      clock,
   input logic      reset,
   rpsr_req_if.sink   req_ch,
   rpsr_rsp_if.source rsp_ch,
   rpsr_csr_if.sink   csr_ch
);
   import rpsr_pkg::*;

   cfg_type    cfg;
   logic       stage_valid;
   stage_type  stage_data;
   logic       stage_ready;
   logic       result_valid;
   result_type result_data;

   rpsr_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   rpsr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_ready (stage_ready)
   );

   rpsr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_ready (stage_ready),
      .rsp_valid   (result_valid),
      .rsp_data    (result_data),
      .rsp_ready   (rsp_ch.ready)
   );

   assign rsp_ch.valid           = result_valid;
   assign rsp_ch.packet_valid    = result_data.packet_valid;
   assign rsp_ch.packet_frames   = result_data.packet_frames;
   assign rsp_ch.read_start      = result_data.read_start;
   assign rsp_ch.consumed_frames = result_data.consumed_frames;
   assign rsp_ch.overflow_seen   = result_data.overflow_seen;
   assign rsp_ch.raised          = result_data.raised;
   assign rsp_ch.lowered         = result_data.lowered;
   assign rsp_ch.underrun_seen   = result_data.underrun_seen;
   assign rsp_ch.no_buffer       = result_data.no_buffer;
   assign rsp_ch.send_refused    = result_data.send_refused;

   // longer and shorter are exclusive decisions
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.raised && rsp_ch.lowered))
      else $error("raised and lowered both set");

   // a sent packet was neither abandoned nor refused
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.packet_valid) |-> (!rsp_ch.no_buffer && !rsp_ch.send_refused))
      else $error("sent packet carries an abandon flag");

   // never more frames taken than the packet holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.consumed_frames <= rsp_ch.packet_frames))
      else $error("consumed frames exceed packet size");

   // a tick taken while the pipe is empty reaches the output through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && !stage_valid && !rsp_ch.valid) |=> ##1 rsp_ch.valid)
      else $error("tick lost between input and result registers");

endmodule

`default_nettype wire

FILE: test/record_packet_size_regulator_checker.sv
// ----------------------------------------------------------------------------
// record_packet_size_regulator_checker
// Watches the tick, decision and register channels of the packet size
// regulator, predicts every decision from its own copy of the read position,
// fill average and started flag, and compares each decision field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module record_packet_size_regulator_checker (
   input  logic clock,
   input  logic reset,
   rpsr_req_if  req_ch,
   rpsr_rsp_if  rsp_ch,
   rpsr_csr_if  csr_ch,
   output int   error_count,
   output int   decisions_pending
);
   import rpsr_pkg::*;

   cfg_type     cfg;
   logic [31:0] read_pos;
   logic [31:0] fill_avg;   // 1/16 frame units
   logic        started;
   result_type  decisions_due[$];

   initial begin
      error_count = 0;
      decisions_pending = 0;
   end

   task automatic flag_mismatch(string msg);
      $display("%0t: decision mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
      end
   endtask

   function automatic result_type size_next_packet(
      logic [31:0] blocks, logic active, logic restarted, logic reopened,
      logic buf_ok, logic send_ok);
      result_type  d;
      logic [31:0] head;
      logic [31:0] delta;
      int          step;
      int          fill;
      int          avg_frames;
      int          frames;
      int          consumed;
      d = '0;
      head = blocks * 32'(BLOCK_FRAMES);
      if (restarted) begin
         read_pos = '0;
         fill_avg = '0;
         started = 1'b0;
      end
      if (reopened) started = 1'b0;
      if (!active) begin
         started = 1'b0;
         return d;
      end
      if (!started) begin
         fill = $signed(head - read_pos);
         if (fill < int'(cfg.target_fill)) return d;
         started = 1'b1;
         fill_avg = (head - read_pos) << 4;
      end
      fill = $signed(head - read_pos);
      if (fill > int'(cfg.max_fill)) begin
         d.overflow_seen = 1'b1;
         read_pos = head - 32'(cfg.target_fill);
         fill_avg = 32'(cfg.target_fill) << 4;
      end
      fill = $signed(head - read_pos);
      // weight 1/8, arithmetic shifts on wrapped 32-bit values
      delta = (32'(fill) << 4) - fill_avg;
      step = $signed(delta) >>> 3;
      fill_avg = fill_avg + 32'(step);
      avg_frames = $signed(fill_avg) >>> 4;

      if (avg_frames > int'(cfg.target_fill) + int'(cfg.band)) begin
         frames = int'(cfg.nominal_frames) + 1;
         d.raised = 1'b1;
      end else if (avg_frames < int'(cfg.target_fill) - int'(cfg.band)) begin
         frames = (cfg.nominal_frames == '0) ? 0 : int'(cfg.nominal_frames) - 1;
         d.lowered = 1'b1;
      end else begin
         frames = int'(cfg.nominal_frames);
      end
      d.packet_frames = 11'(frames);
      d.read_start = read_pos;

      if (!buf_ok) begin
         d.no_buffer = 1'b1;
         return d;
      end
      if (fill < frames) begin
         d.underrun_seen = 1'b1;
         consumed = (fill > 0) ? fill : 0;
      end else begin
         consumed = frames;
      end
      d.consumed_frames = 11'(consumed);
      // a refused send leaves the read position where it was
      if (!send_ok) d.send_refused = 1'b1;
      else begin
         read_pos = read_pos + 32'(consumed);
         d.packet_valid = 1'b1;
      end
      return d;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         cfg.nominal_frames = NOMINAL_FRAMES_RESET;
         cfg.target_fill = TARGET_FILL_RESET;
         cfg.band = BAND_RESET;
         cfg.max_fill = MAX_FILL_RESET;
         read_pos = '0;
         fill_avg = '0;
         started = 1'b0;
         decisions_due.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_NOMINAL_FRAMES: cfg.nominal_frames = csr_ch.wdata[9:0];
               REG_TARGET_FILL:    cfg.target_fill = csr_ch.wdata;
               REG_BAND:           cfg.band = csr_ch.wdata[7:0];
               REG_MAX_FILL:       cfg.max_fill = csr_ch.wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            decisions_due.push_back(size_next_packet(req_ch.rx_blocks_done,
               req_ch.record_active, req_ch.port_restarted, req_ch.stream_reopened,
               req_ch.buffer_free, req_ch.send_accepted));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.packet_valid = rsp_ch.packet_valid;
            got.packet_frames = rsp_ch.packet_frames;
            got.read_start = rsp_ch.read_start;
            got.consumed_frames = rsp_ch.consumed_frames;
            got.overflow_seen = rsp_ch.overflow_seen;
            got.raised = rsp_ch.raised;
            got.lowered = rsp_ch.lowered;
            got.underrun_seen = rsp_ch.underrun_seen;
            got.no_buffer = rsp_ch.no_buffer;
            got.send_refused = rsp_ch.send_refused;
            if (decisions_due.size() == 0) begin
               flag_mismatch("decision transfer with none outstanding");
            end else begin
               want = decisions_due.pop_front();
               check_field("packet_valid", 32'(got.packet_valid),
                           32'(want.packet_valid));
               check_field("packet_frames", 32'(got.packet_frames),
                           32'(want.packet_frames));
               check_field("read_start", got.read_start, want.read_start);
               check_field("consumed_frames", 32'(got.consumed_frames),
                           32'(want.consumed_frames));
               check_field("overflow_seen", 32'(got.overflow_seen),
                           32'(want.overflow_seen));
               check_field("raised", 32'(got.raised), 32'(want.raised));
               check_field("lowered", 32'(got.lowered), 32'(want.lowered));
               check_field("underrun_seen", 32'(got.underrun_seen),
                           32'(want.underrun_seen));
               check_field("no_buffer", 32'(got.no_buffer), 32'(want.no_buffer));
               check_field("send_refused", 32'(got.send_refused),
                           32'(want.send_refused));
            end
         end
      end
      decisions_pending = decisions_due.size();
   end

endmodule

`default_nettype wire

FILE: test/record_packet_size_regulator_tb.sv
// ----------------------------------------------------------------------------
// record_packet_size_regulator_tb
// Drives start-of-frame ticks into the packet size regulator through a
// directed opening and phases of random ring traffic under several register
// settings, with random stalls on both channels; the checker beside the
// block predicts and compares every decision.
// ----------------------------------------------------------------------------
`default_nettype none

module record_packet_size_regulator_tb;
   import rpsr_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int TICKS_PER_PHASE = 100;
   localparam csr_index_type UNUSED_INDEX = csr_index_type'(8'hFF);

   localparam logic [9:0]  FIX_NOMINAL [6] = '{10'd48, 10'd1023, 10'd2, 10'd0,
                                               10'd1, 10'd100};
   localparam logic [15:0] FIX_TARGET  [6] = '{16'd96, 16'd65535, 16'd0,
                                               16'd200, 16'd50, 16'd1000};
   localparam logic [7:0]  FIX_BAND    [6] = '{8'd8, 8'd255, 8'd0, 8'd0,
                                               8'd255, 8'd20};
   localparam logic [15:0] FIX_MAX     [6] = '{16'd288, 16'd65535, 16'd0,
                                               16'd500, 16'd100, 16'd3000};

   logic        clock;
   logic        reset;
   int          error_count;
   int          decisions_pending;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;      // no random idling on either side
   bit          hold_rsp = 1'b0;   // ask the receiver for one long hold-off
   logic [31:0] blocks;
   logic [9:0]  cur_nominal;
   logic [15:0] cur_target;

   rpsr_req_if req_ch ();
   rpsr_rsp_if rsp_ch ();
   rpsr_csr_if csr_ch ();

   record_packet_size_regulator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   record_packet_size_regulator_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_ch),
      .rsp_ch            (rsp_ch),
      .csr_ch            (csr_ch),
      .error_count       (error_count),
      .decisions_pending (decisions_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // decision receiver
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            stall = 150;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_tick(logic [31:0] blk, logic act, logic rst, logic reo,
                            logic buf_ok, logic snd);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_blocks_done <= blk;
      req_ch.record_active <= act;
      req_ch.port_restarted <= rst;
      req_ch.stream_reopened <= reo;
      req_ch.buffer_free <= buf_ok;
      req_ch.send_accepted <= snd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // sender stops until every outstanding decision has arrived
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (decisions_pending == 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(logic [9:0] nom, logic [15:0] tgt, logic [7:0] bnd,
                             logic [15:0] mx);
      drain();
      // unused upper write data bits carry noise
      write_reg(REG_NOMINAL_FRAMES, {6'($urandom), nom});
      write_reg(REG_TARGET_FILL, tgt);
      write_reg(REG_BAND, {8'($urandom), bnd});
      write_reg(REG_MAX_FILL, mx);
      cur_nominal = nom;
      cur_target = tgt;
   endtask

   task automatic random_tick();
      int pick;
      int rate;
      int inc;
      pick = $urandom_range(0, 99);
      // block rate that roughly matches the packet drain
      rate = (int'(cur_nominal) + 24) / 48;
      if (pick < 4) begin
         send_tick(blocks, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
      end else if (pick < 7) begin
         blocks = 32'(int'(cur_target) / 48 + int'($urandom_range(0, 3)));
         send_tick(blocks, 1'b1, 1'b1, 1'($urandom), 1'b1, 1'b1);
      end else if (pick < 9) begin
         if ($urandom_range(0, 1) == 0) blocks = $urandom;
         else blocks = 32'hFFFF_FFFF - $urandom_range(0, 40);
         send_tick(blocks, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      end else if (pick < 11) begin
         send_tick(blocks, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
      end else begin
         inc = rate - 1 + int'($urandom_range(0, 2));
         if (inc < 0) inc = 0;
         blocks = blocks + 32'(inc);
         send_tick(blocks, 1'b1, 1'b0, 1'b0, $urandom_range(0, 19) != 0,
                   $urandom_range(0, 19) != 0);
      end
   endtask

   initial begin
      logic [15:0] rnd_target;
      int          rnd_max;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_blocks_done <= '0;
      req_ch.record_active <= 1'b0;
      req_ch.port_restarted <= 1'b0;
      req_ch.stream_reopened <= 1'b0;
      req_ch.buffer_free <= 1'b0;
      req_ch.send_accepted <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.wdata <= '0;
      blocks = '0;
      cur_nominal = NOMINAL_FRAMES_RESET;
      cur_target = TARGET_FILL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening on reset settings
      send_tick(32'd5, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);        // inactive
      send_tick(32'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);        // below start level
      send_tick(32'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);        // start exactly at target
      send_tick(32'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(32'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(32'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);        // ring runs dry
      send_tick(32'd20, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);       // overflow skip
      send_tick(32'd21, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);       // no buffer
      send_tick(32'd22, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);       // refused, rolled back
      send_tick(32'd23, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);       // reopen
      send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1); // restart, head wraps
      send_tick(32'h0000_0001, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
      send_tick(32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1); // head wraps to zero
      send_tick(32'h5555_5555, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
      send_tick(32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_tick(32'hAAAA_AAAB, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      drain();
      write_reg(UNUSED_INDEX, 16'hFFFF);

      for (int p = 0; p < PHASES; p++) begin
         if (p < 6) begin
            set_config(FIX_NOMINAL[p], FIX_TARGET[p], FIX_BAND[p], FIX_MAX[p]);
         end else begin
            rnd_target = 16'($urandom_range(0, 4000));
            rnd_max = int'(rnd_target) + int'($urandom_range(0, 3000));
            set_config(10'($urandom_range(0, 1023)), rnd_target, 8'($urandom),
                       16'(rnd_max));
         end
         if (p == PHASES - 1) quiet = 1'b1;
         blocks = 32'(int'(cur_target) / 48 + 2);
         send_tick(blocks, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
         repeat (TICKS_PER_PHASE - 1) random_tick();
         if (p == 2) begin
            // receiver holds off while ticks keep coming
            hold_rsp = 1'b1;
            quiet = 1'b1;
            repeat (24) random_tick();
            quiet = 1'b0;
            drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0 && decisions_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
design/rpsr_pkg.sv
design/rpsr_req_if.sv
design/rpsr_rsp_if.sv
design/rpsr_csr_if.sv
design/rpsr_csr_regs.sv
design/rpsr_in_stage.sv
design/rpsr_core.sv
design/record_packet_size_regulator.sv
test/record_packet_size_regulator_checker.sv
test/record_packet_size_regulator_tb.sv
